// ===== src/tpz_pkg.sv =====
package tpz_pkg;

  localparam int SCREEN_ROWS_DEF = 50;
  localparam int SCREEN_COLS_DEF = 75;
  localparam int CENTER_COL = 37;
  localparam int CENTER_ROW = 15;
  localparam int ONE_Q14 = 16384;
  localparam int COL_SCALE = 156;
  localparam int ROW_SCALE = 72;
  localparam int DEN_SCALE = 100;
  localparam int SHADE_MAX = 11;

  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 17;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 40;
  localparam int DIV_D_W = 33;
  localparam int Q_CUT = 10;

  localparam logic [DIV_N_W-1:0] INV_NUM = 40'h00_4000_0000;
  localparam logic [7:0] GLYPH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    FN_CLEAR = 2'd0,
    FN_PLOT  = 2'd1,
    FN_READ  = 2'd2,
    FN_NOP   = 2'd3
  } fn_t;

  typedef enum logic [2:0] {
    CFG_MAJOR_RADIUS    = 3'd0,
    CFG_MINOR_RADIUS    = 3'd1,
    CFG_CAMERA_DISTANCE = 3'd2,
    CFG_OBJECT_DISTANCE = 3'd3,
    CFG_COS_YAW         = 3'd4,
    CFG_SIN_YAW         = 3'd5,
    CFG_COS_PITCH       = 3'd6,
    CFG_SIN_PITCH       = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_TUBE, ST_RING, ST_Z, ST_X, ST_Y, ST_RX_A, ST_RX, ST_RZ_A, ST_RZ,
    ST_NX, ST_NY, ST_RY_A, ST_RY, ST_DEPTH_A, ST_DEPTH, ST_RNZ_A, ST_RNZ,
    ST_RRNY_A, ST_RRNY, ST_RRNZ_A, ST_RRNZ, ST_CAMX, ST_CAMY, ST_NUMC,
    ST_NUMR, ST_DEN
  } step_t;

  typedef enum logic [1:0] {
    DIV_COL,
    DIV_ROW,
    DIV_INV
  } div_sel_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_MATH, S_PROJ, S_DIV_COL, S_DIV_ROW,
    S_DIV_INV, S_LOOKUP, S_UPDATE, S_READ, S_DONE
  } state_t;

  typedef struct packed {
    logic     latch;
    logic     sweep;
    logic     step_en;
    step_t    step;
    logic     div_start;
    div_sel_t div_sel;
    logic     lookup;
    logic     update;
    logic     read_en;
    logic     res_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic div_busy;
    logic depth_pos;
    logic on_screen;
    logic res_free;
  } sts_t;

  function automatic logic [7:0] shade_glyph(input logic [3:0] s);
    logic [7:0] g;
    unique case (s)
      4'd0:    g = 8'h2E;
      4'd1:    g = 8'h2C;
      4'd2:    g = 8'h2D;
      4'd3:    g = 8'h7E;
      4'd4:    g = 8'h3A;
      4'd5:    g = 8'h3B;
      4'd6:    g = 8'h3D;
      4'd7:    g = 8'h21;
      4'd8:    g = 8'h2A;
      4'd9:    g = 8'h23;
      4'd10:   g = 8'h24;
      4'd11:   g = 8'h40;
      default: g = GLYPH_SPACE;
    endcase
    return g;
  endfunction

endpackage

// ===== src/torus_point_zbuffer_plotter.sv =====
// Plot: 26 steps of the shared multiplier, then 40-step divisions for column and
//   row (if depth > 0), then inverse depth and a store update (if on screen).
// Read: a registered store read. Clear: a sweep, one cell per cycle.
// A new word is taken once the previous one has gone to the output register.
// Reset: a clearing pass over SCREEN_ROWS*SCREEN_COLS cells (3750 by default)
//   runs with in_stall high; configuration returns to its reset values.
module torus_point_zbuffer_plotter import tpz_pkg::*; #(
  parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS = SCREEN_COLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic signed [15:0] cos_ring,
  input  logic signed [15:0] sin_ring,
  input  logic signed [15:0] cos_tube,
  input  logic signed [15:0] sin_tube,
  input  logic [5:0]         read_row,
  input  logic [6:0]         read_col,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         glyph,
  output logic               written,
  output logic [5:0]         cell_row,
  output logic [6:0]         cell_col,
  output logic [3:0]         shade,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tpz_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_func  (func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpz_dp #(
    .SCREEN_ROWS(SCREEN_ROWS),
    .SCREEN_COLS(SCREEN_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .func      (func),
    .cos_ring  (cos_ring),
    .sin_ring  (sin_ring),
    .cos_tube  (cos_tube),
    .sin_tube  (sin_tube),
    .read_row  (read_row),
    .read_col  (read_col),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .glyph     (glyph),
    .written   (written),
    .cell_row  (cell_row),
    .cell_col  (cell_col),
    .shade     (shade)
  );

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  a_written_glyph: assert property (@(posedge clk) disable iff (rst)
    out_valid && written |-> glyph != GLYPH_SPACE)
    else $error("written word carries a blank glyph");

  a_init_stall: assert property (@(posedge clk)
    $past(rst) |-> in_stall)
    else $error("input taken during clearing pass");

endmodule

// ===== src/tpz_div.sv =====
module tpz_div import tpz_pkg::*; #(
  parameter int N_W = DIV_N_W,
  parameter int D_W = DIV_D_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(N_W);

  logic             run;
  logic             fin;
  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   rem;
  logic [N_W-1:0]   quo;
  logic [D_W-1:0]   dvs;
  logic [D_W:0]     rem_sh;
  logic [D_W+1:0]   diff;
  logic             fits;

  assign rem_sh = {rem, quo[N_W-1]};
  assign diff = {1'b0, rem_sh} - {2'b00, dvs};
  assign fits = ~diff[D_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      fin <= run && (cnt == '0);
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(N_W - 1);
      end else if (run) begin
        if (cnt == '0) begin
          run <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (run) begin
      rem <= fits ? diff[D_W-1:0] : rem_sh[D_W-1:0];
      quo <= {quo[N_W-2:0], fits};
    end
  end

  assign busy = run | fin;
  assign done = fin;
  assign quotient = quo;

endmodule

// ===== src/tpz_ctrl.sv =====
module tpz_ctrl import tpz_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  output logic       in_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state, state_next;
  step_t  step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      step  <= ST_TUBE;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.step   = step;
    cmd.div_sel = DIV_COL;
    in_stall   = 1'b1;
    unique case (state)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          unique case (fn_t'(in_func))
            FN_CLEAR: state_next = S_CLEAR;
            FN_PLOT:  state_next = S_MATH;
            FN_READ:  state_next = S_READ;
            FN_NOP:   state_next = S_DONE;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) state_next = S_DONE;
      end
      S_MATH: begin
        cmd.step_en = 1'b1;
        if (step == ST_DEN) begin
          step_next  = ST_TUBE;
          state_next = S_PROJ;
        end else begin
          step_next = step_t'(step + 1'b1);
        end
      end
      S_PROJ: begin
        if (sts.depth_pos) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_COL;
          state_next    = S_DIV_COL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV_COL: begin
        if (!sts.div_busy) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_ROW;
          state_next    = S_DIV_ROW;
        end
      end
      S_DIV_ROW: begin
        if (!sts.div_busy) begin
          if (sts.on_screen) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_INV;
            state_next    = S_DIV_INV;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DIV_INV: begin
        if (!sts.div_busy) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_DONE;
      end
      S_READ: begin
        cmd.read_en = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (sts.res_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

// ===== src/tpz_dp.sv =====
module tpz_dp import tpz_pkg::*; #(
  parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS = SCREEN_COLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [1:0]         func,
  input  logic signed [15:0] cos_ring,
  input  logic signed [15:0] sin_ring,
  input  logic signed [15:0] cos_tube,
  input  logic signed [15:0] sin_tube,
  input  logic [5:0]         read_row,
  input  logic [6:0]         read_col,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [7:0]         glyph,
  output logic               written,
  output logic [5:0]         cell_row,
  output logic [6:0]         cell_col,
  output logic [3:0]         shade
);

  localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW = $clog2(CELLS);
  localparam int RW = $clog2(SCREEN_ROWS);
  localparam int CW = $clog2(SCREEN_COLS);

  logic [5:0]         major_radius;
  logic [5:0]         minor_radius;
  logic [7:0]         camera_distance;
  logic [7:0]         object_distance;
  logic signed [15:0] cos_yaw;
  logic signed [15:0] sin_yaw;
  logic signed [15:0] cos_pitch;
  logic signed [15:0] sin_pitch;

  fn_t                func_q;
  logic signed [15:0] cr, sr, ct, st;
  logic [5:0]         rd_row;
  logic [6:0]         rd_col;

  logic signed [PROD_W-1:0]  prod, acc;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_s, sum_s, dif_s, ring_full, depth_full;
  logic signed [22:0] ring;
  logic signed [21:0] z;
  logic signed [23:0] x, y;
  logic signed [25:0] rx, rz;
  logic signed [26:0] ry, depth;
  logic signed [17:0] nx, ny;
  logic signed [18:0] rnz;
  logic signed [20:0] rrny, rrnz;
  logic signed [32:0] t1;
  logic signed [34:0] t2;
  logic signed [40:0] numc, numr, numc_mag, numr_mag;
  logic [DIV_D_W-1:0] den;
  logic [3:0]         shade_q, shade_next;
  logic signed [21:0] lit;
  logic signed [25:0] lit11;

  logic [DIV_N_W-1:0] div_n, div_q;
  logic [DIV_D_W-1:0] div_d;
  logic               div_busy, div_done;
  div_sel_t           div_dest;
  logic               div_neg;
  logic signed [11:0] q_ext, col_s, row_s;
  logic               col_big, row_big;
  logic [15:0]        inv;
  logic               hit;

  logic [23:0]   mem [CELLS];
  logic [23:0]   mem_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra, plot_addr, read_addr, sweep_cnt;
  logic [23:0]   mem_wd;
  logic          better, read_in, wr_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      major_radius    <= 6'd20;
      minor_radius    <= 6'd8;
      camera_distance <= 8'd15;
      object_distance <= 8'd35;
      cos_yaw         <= 16'sd16384;
      sin_yaw         <= 16'sd0;
      cos_pitch       <= 16'sd16384;
      sin_pitch       <= 16'sd0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAJOR_RADIUS:    major_radius    <= cfg_data[5:0];
        CFG_MINOR_RADIUS:    minor_radius    <= cfg_data[5:0];
        CFG_CAMERA_DISTANCE: camera_distance <= cfg_data[7:0];
        CFG_OBJECT_DISTANCE: object_distance <= cfg_data[7:0];
        CFG_COS_YAW:         cos_yaw         <= cfg_data;
        CFG_SIN_YAW:         sin_yaw         <= cfg_data;
        CFG_COS_PITCH:       cos_pitch       <= cfg_data;
        CFG_SIN_PITCH:       sin_pitch       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q <= fn_t'(func);
      cr     <= cos_ring;
      sr     <= sin_ring;
      ct     <= cos_tube;
      st     <= sin_tube;
      rd_row <= read_row;
      rd_col <= read_col;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      ST_TUBE:    begin mul_a = MUL_A_W'(minor_radius); mul_b = MUL_B_W'(st); end
      ST_RING:    begin mul_a = MUL_A_W'(minor_radius); mul_b = MUL_B_W'(ct); end
      ST_Z:       begin mul_a = MUL_A_W'(ring);  mul_b = MUL_B_W'(cr); end
      ST_X:       begin mul_a = MUL_A_W'(ring);  mul_b = MUL_B_W'(sr); end
      ST_Y:       begin mul_a = MUL_A_W'(x);     mul_b = MUL_B_W'(cos_yaw); end
      ST_RX_A:    begin mul_a = MUL_A_W'(z);     mul_b = MUL_B_W'(sin_yaw); end
      ST_RX:      begin mul_a = MUL_A_W'(z);     mul_b = MUL_B_W'(cos_yaw); end
      ST_RZ_A:    begin mul_a = MUL_A_W'(x);     mul_b = MUL_B_W'(sin_yaw); end
      ST_RZ:      begin mul_a = MUL_A_W'(cr);    mul_b = MUL_B_W'(st); end
      ST_NX:      begin mul_a = MUL_A_W'(sr);    mul_b = MUL_B_W'(st); end
      ST_NY:      begin mul_a = MUL_A_W'(y);     mul_b = MUL_B_W'(cos_pitch); end
      ST_RY_A:    begin mul_a = MUL_A_W'(rz);    mul_b = MUL_B_W'(sin_pitch); end
      ST_RY:      begin mul_a = MUL_A_W'(rz);    mul_b = MUL_B_W'(cos_pitch); end
      ST_DEPTH_A: begin mul_a = MUL_A_W'(y);     mul_b = MUL_B_W'(sin_pitch); end
      ST_DEPTH:   begin mul_a = MUL_A_W'(ct);    mul_b = MUL_B_W'(cos_yaw); end
      ST_RNZ_A:   begin mul_a = MUL_A_W'(nx);    mul_b = MUL_B_W'(sin_yaw); end
      ST_RNZ:     begin mul_a = MUL_A_W'(ny);    mul_b = MUL_B_W'(cos_pitch); end
      ST_RRNY_A:  begin mul_a = MUL_A_W'(rnz);   mul_b = MUL_B_W'(sin_pitch); end
      ST_RRNY:    begin mul_a = MUL_A_W'(rnz);   mul_b = MUL_B_W'(cos_pitch); end
      ST_RRNZ_A:  begin mul_a = MUL_A_W'(ny);    mul_b = MUL_B_W'(sin_pitch); end
      ST_RRNZ:    begin mul_a = MUL_A_W'(rx);    mul_b = MUL_B_W'(camera_distance); end
      ST_CAMX:    begin mul_a = MUL_A_W'(ry);    mul_b = MUL_B_W'(camera_distance); end
      ST_CAMY:    begin mul_a = MUL_A_W'(t1);    mul_b = MUL_B_W'(COL_SCALE); end
      ST_NUMC:    begin mul_a = MUL_A_W'(t2);    mul_b = MUL_B_W'(ROW_SCALE); end
      ST_NUMR:    begin mul_a = MUL_A_W'(depth); mul_b = MUL_B_W'(DEN_SCALE); end
      default:    begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_s = prod >>> 14;
  assign sum_s = (acc + prod) >>> 14;
  assign dif_s = (acc - prod) >>> 14;
  assign ring_full = PROD_W'({major_radius, 14'b0}) + prod;
  assign depth_full = PROD_W'({object_distance, 14'b0}) + dif_s;

  assign lit = 22'(rrny) - 22'(rrnz) + 22'(ONE_Q14);
  assign lit11 = 26'(lit) * 26'(SHADE_MAX);
  always_comb begin
    if (lit11[25]) begin
      shade_next = 4'd0;
    end else if (lit11[24:15] > 10'(SHADE_MAX)) begin
      shade_next = 4'(SHADE_MAX);
    end else begin
      shade_next = lit11[18:15];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_en) begin
      prod <= PROD_W'(mul_a * mul_b);
      case (cmd.step)
        ST_RING:    ring  <= ring_full[22:0];
        ST_Z:       z     <= prod[21:0];
        ST_X:       x     <= prod_s[23:0];
        ST_Y:       y     <= prod_s[23:0];
        ST_RX_A:    acc   <= prod;
        ST_RX:      rx    <= sum_s[25:0];
        ST_RZ_A:    acc   <= prod;
        ST_RZ:      rz    <= dif_s[25:0];
        ST_NX:      nx    <= prod_s[17:0];
        ST_NY:      ny    <= prod_s[17:0];
        ST_RY_A:    acc   <= prod;
        ST_RY:      ry    <= sum_s[26:0];
        ST_DEPTH_A: acc   <= prod;
        ST_DEPTH:   depth <= depth_full[26:0];
        ST_RNZ_A:   acc   <= prod;
        ST_RNZ:     rnz   <= dif_s[18:0];
        ST_RRNY_A:  acc   <= prod;
        ST_RRNY:    rrny  <= sum_s[20:0];
        ST_RRNZ_A:  acc   <= prod;
        ST_RRNZ:    rrnz  <= dif_s[20:0];
        ST_CAMX:    t1    <= prod[32:0];
        ST_CAMY:    t2    <= prod[34:0];
        ST_NUMC:    numc  <= prod[40:0];
        ST_NUMR:    numr  <= prod[40:0];
        ST_DEN: begin
          den     <= prod[DIV_D_W-1:0];
          shade_q <= shade_next;
        end
        default: ;
      endcase
    end
  end

  assign numc_mag = numc[40] ? -numc : numc;
  assign numr_mag = numr[40] ? -numr : numr;

  always_comb begin
    case (cmd.div_sel)
      DIV_COL: begin div_n = numc_mag[DIV_N_W-1:0]; div_d = den; end
      DIV_ROW: begin div_n = numr_mag[DIV_N_W-1:0]; div_d = den; end
      default: begin div_n = INV_NUM; div_d = DIV_D_W'(depth); end
    endcase
  end

  tpz_div #(
    .N_W(DIV_N_W),
    .D_W(DIV_D_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_ext = signed'({2'b00, div_q[Q_CUT-1:0]});

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_dest <= cmd.div_sel;
      div_neg  <= (cmd.div_sel == DIV_COL) ? numc[40] :
                  (cmd.div_sel == DIV_ROW) ? numr[40] : 1'b0;
    end
    if (div_done) begin
      case (div_dest)
        DIV_COL: begin
          col_big <= |div_q[DIV_N_W-1:Q_CUT];
          col_s   <= div_neg ? 12'(CENTER_COL) - q_ext : 12'(CENTER_COL) + q_ext;
        end
        DIV_ROW: begin
          row_big <= |div_q[DIV_N_W-1:Q_CUT];
          row_s   <= div_neg ? 12'(CENTER_ROW) + q_ext : 12'(CENTER_ROW) - q_ext;
        end
        default: inv <= (|div_q[DIV_N_W-1:16]) ? 16'hFFFF : div_q[15:0];
      endcase
    end
  end

  assign sts.on_screen = !col_big && !row_big && !col_s[11] && !row_s[11] &&
                         (col_s < 12'(SCREEN_COLS)) && (row_s < 12'(SCREEN_ROWS));
  assign sts.depth_pos = !depth[26] && (|depth);
  assign sts.div_busy  = div_busy;
  assign hit = sts.depth_pos && sts.on_screen;

  assign plot_addr = AW'(int'(row_s[RW-1:0]) * SCREEN_COLS + int'(col_s[CW-1:0]));
  assign read_addr = AW'(int'(rd_row) * SCREEN_COLS + int'(rd_col));
  assign read_in = (int'(rd_row) < SCREEN_ROWS) && (int'(rd_col) < SCREEN_COLS);
  assign better = inv > mem_q[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sts.sweep_last ? '0 : sweep_cnt + 1'b1;
    end
  end
  assign sts.sweep_last = sweep_cnt == AW'(CELLS - 1);

  assign mem_we = cmd.sweep || (cmd.update && better);
  assign mem_wa = cmd.sweep ? sweep_cnt : plot_addr;
  assign mem_wd = cmd.sweep ? {GLYPH_SPACE, 16'h0000} : {shade_glyph(shade_q), inv};
  assign mem_re = cmd.lookup || cmd.read_en;
  assign mem_ra = cmd.read_en ? read_addr : plot_addr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (mem_re) mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      wr_flag <= 1'b0;
    end else if (cmd.update) begin
      wr_flag <= better;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
  assign sts.res_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      glyph    <= 8'h00;
      written  <= 1'b0;
      cell_row <= 6'd0;
      cell_col <= 7'd0;
      shade    <= 4'd0;
      case (func_q)
        FN_CLEAR: glyph <= GLYPH_SPACE;
        FN_PLOT: begin
          glyph   <= shade_glyph(shade_q);
          shade   <= shade_q;
          written <= wr_flag;
          if (hit) begin
            cell_row <= row_s[5:0];
            cell_col <= col_s[6:0];
          end
        end
        FN_READ: begin
          glyph    <= read_in ? mem_q[23:16] : GLYPH_SPACE;
          cell_row <= rd_row;
          cell_col <= rd_col;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/sv/torus_point_zbuffer_plotter_test.sv =====
`timescale 1ns / 100ps

module torus_point_zbuffer_plotter_test;
  import tpz_pkg::*;

  localparam int ROWS = 50;
  localparam int COLS = 75;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    fn_t               func;
    logic signed [15:0] cos_ring;
    logic signed [15:0] sin_ring;
    logic signed [15:0] cos_tube;
    logic signed [15:0] sin_tube;
    logic [5:0]        read_row;
    logic [6:0]        read_col;
  } point_t;

  typedef struct packed {
    logic [7:0] glyph;
    logic       written;
    logic [5:0] cell_row;
    logic [6:0] cell_col;
    logic [3:0] shade;
  } cell_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = FN_NOP;
  logic signed [15:0] cos_ring = '0, sin_ring = '0, cos_tube = '0, sin_tube = '0;
  logic [5:0] read_row = '0;
  logic [6:0] read_col = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] glyph;
  logic written;
  logic [5:0] cell_row;
  logic [6:0] cell_col;
  logic [3:0] shade;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = CFG_MAJOR_RADIUS;
  logic [15:0] cfg_data = '0;

  torus_point_zbuffer_plotter u_dut (.*);

  // model state
  logic [5:0]  m_major, m_minor;
  logic [7:0]  m_cam, m_obj;
  logic signed [15:0] m_cy, m_sy, m_cp, m_sp;
  logic [7:0]  glyph_mem [ROWS*COLS];
  logic [15:0] inv_depth_mem [ROWS*COLS];
  string shade_chars = ".,-~:;=!*#$@";

  cell_t pending_cells[$];
  int lit_rows[$];
  int lit_cols[$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  logic hold_kick = 1'b0;
  bit valid_up = 0;
  int n_plot = 0, n_hit = 0, n_read = 0, n_clear = 0, n_nop = 0, n_views = 0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending_cells.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_kick)
      hold_left <= 3000;
    else if (hold_left > 0)
      hold_left <= hold_left - 1;
  end

  always @(posedge clk)
    out_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);

  task automatic report(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cell_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_cells.size() == 0) begin
        report("unexpected word, glyph", glyph, 0);
      end else begin
        want = pending_cells.pop_front();
        if (glyph !== want.glyph) report("glyph", glyph, want.glyph);
        if (written !== want.written) report("written", written, want.written);
        if (cell_row !== want.cell_row) report("cell_row", cell_row, want.cell_row);
        if (cell_col !== want.cell_col) report("cell_col", cell_col, want.cell_col);
        if (shade !== want.shade) report("shade", shade, want.shade);
      end
    end
  end

  function automatic void wipe_frame();
    for (int i = 0; i < ROWS*COLS; i++) begin
      glyph_mem[i] = 8'h20;
      inv_depth_mem[i] = '0;
    end
  endfunction

  function automatic cell_t predict_cell(input point_t p);
    cell_t r;
    longint cr, sr, ct, st, cy, sy, cp, sp, bigr, smallr, cam;
    longint ring, x, y, z, rx, rz, ry, depth, nx, ny, rnz, rrny, rrnz, lit, sh;
    longint col, row, inv;
    int idx;
    r = '0;
    case (p.func)
      FN_CLEAR: begin
        wipe_frame();
        r.glyph = 8'h20;
      end
      FN_READ: begin
        r.cell_row = p.read_row;
        r.cell_col = p.read_col;
        r.glyph = 8'h20;
        if (p.read_row < ROWS && p.read_col < COLS)
          r.glyph = glyph_mem[p.read_row * COLS + p.read_col];
      end
      FN_PLOT: begin
        cr = p.cos_ring; sr = p.sin_ring; ct = p.cos_tube; st = p.sin_tube;
        cy = m_cy; sy = m_sy; cp = m_cp; sp = m_sp;
        bigr = longint'(m_major); smallr = longint'(m_minor); cam = longint'(m_cam);
        ring = bigr * 16384 + smallr * st;
        x = (cr * ring) >>> 14;
        y = (sr * ring) >>> 14;
        z = smallr * ct;
        rx = (x * cy + z * sy) >>> 14;
        rz = (z * cy - x * sy) >>> 14;
        ry = (y * cp + rz * sp) >>> 14;
        depth = longint'(m_obj) * 16384 + ((rz * cp - y * sp) >>> 14);
        nx = (cr * st) >>> 14;
        ny = (sr * st) >>> 14;
        rnz = (ct * cy - nx * sy) >>> 14;
        rrny = (ny * cp + rnz * sp) >>> 14;
        rrnz = (rnz * cp - ny * sp) >>> 14;
        lit = (rrny - rrnz + 16384) * 11;
        sh = (lit < 0) ? 0 : (lit >> 15);
        if (sh > 11) sh = 11;
        r.shade = sh[3:0];
        r.glyph = shade_chars[sh];
        if (depth > 0) begin
          col = 37 + (cam * rx * 156) / (100 * depth);
          row = 15 - (cam * ry * 72) / (100 * depth);
          if (col >= 0 && col < COLS && row >= 0 && row < ROWS) begin
            inv = (longint'(1) << 30) / depth;
            if (inv > 65535) inv = 65535;
            idx = int'(row) * COLS + int'(col);
            r.cell_row = row[5:0];
            r.cell_col = col[6:0];
            if (inv > longint'(inv_depth_mem[idx])) begin
              inv_depth_mem[idx] = inv[15:0];
              glyph_mem[idx] = r.glyph;
              r.written = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(input point_t p);
    cell_t want;
    in_valid <= 1'b1;
    valid_up = 1;
    func <= p.func;
    cos_ring <= p.cos_ring;
    sin_ring <= p.sin_ring;
    cos_tube <= p.cos_tube;
    sin_tube <= p.sin_tube;
    read_row <= p.read_row;
    read_col <= p.read_col;
    do @(posedge clk); while (in_stall);
    want = predict_cell(p);
    pending_cells.push_back(want);
    case (p.func)
      FN_PLOT: begin
        n_plot++;
        if (want.written) begin
          n_hit++;
          lit_rows.push_back(want.cell_row);
          lit_cols.push_back(want.cell_col);
          if (lit_rows.size() > 64) begin
            void'(lit_rows.pop_front());
            void'(lit_cols.pop_front());
          end
        end
      end
      FN_READ: n_read++;
      FN_CLEAR: n_clear++;
      default: n_nop++;
    endcase
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      valid_up = 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drop_valid();
    if (valid_up) in_valid <= 1'b0;
    valid_up = 0;
  endtask

  task automatic drain();
    drop_valid();
    @(posedge clk);
    wait (pending_cells.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_view(input int maj, input int mnr, input int cam, input int obj,
                            input int cy, input int sy, input int cp, input int sp);
    logic [15:0] vals[8];
    drain();
    vals = '{maj, mnr, cam, obj, cy, sy, cp, sp};
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    m_major = vals[0][5:0];
    m_minor = vals[1][5:0];
    m_cam = vals[2][7:0];
    m_obj = vals[3][7:0];
    m_cy = vals[4]; m_sy = vals[5]; m_cp = vals[6]; m_sp = vals[7];
    n_views++;
    @(posedge clk);
  endtask

  function automatic int q14(input real v);
    return $rtoi($floor(16384.0 * v + 0.5));
  endfunction

  function automatic int rand_q14();
    case ($urandom_range(5))
      0: return -16384;
      1: return 16384;
      2: return 0;
      default: return int'($urandom_range(32768)) - 16384;
    endcase
  endfunction

  task automatic random_view();
    real a, b;
    a = 6.2832 * $urandom_range(999) / 1000.0;
    b = 6.2832 * $urandom_range(999) / 1000.0;
    write_view($urandom_range(8, 30), $urandom_range(2, 15), $urandom_range(8, 60),
               $urandom_range(20, 70), q14($cos(a)), q14($sin(a)), q14($cos(b)), q14($sin(b)));
  endtask

  function automatic point_t make_point(input fn_t f, input int cr, input int sr,
                                        input int ct, input int st, input int r, input int c);
    point_t p;
    p.func = f;
    p.cos_ring = cr; p.sin_ring = sr; p.cos_tube = ct; p.sin_tube = st;
    p.read_row = r; p.read_col = c;
    return p;
  endfunction

  function automatic point_t random_point();
    int pick;
    real t, u;
    int k;
    pick = $urandom_range(99);
    if (pick < 78) begin
      t = 6.2832 * $urandom_range(9999) / 10000.0;
      u = 6.2832 * $urandom_range(9999) / 10000.0;
      return make_point(FN_PLOT, q14($cos(t)), q14($sin(t)), q14($cos(u)), q14($sin(u)),
                        $urandom_range(63), $urandom_range(127));
    end else if (pick < 88) begin
      return make_point(FN_PLOT, rand_q14(), rand_q14(), rand_q14(), rand_q14(),
                        $urandom_range(63), $urandom_range(127));
    end else if (pick < 96) begin
      if (lit_rows.size() > 0 && $urandom_range(2) != 0) begin
        k = $urandom_range(lit_rows.size() - 1);
        return make_point(FN_READ, rand_q14(), rand_q14(), rand_q14(), rand_q14(),
                          lit_rows[k], lit_cols[k]);
      end
      return make_point(FN_READ, rand_q14(), rand_q14(), rand_q14(), rand_q14(),
                        $urandom_range(63), $urandom_range(127));
    end else if (pick < 98) begin
      return make_point(FN_NOP, rand_q14(), rand_q14(), rand_q14(), rand_q14(),
                        $urandom_range(63), $urandom_range(127));
    end
    return make_point(FN_CLEAR, rand_q14(), rand_q14(), rand_q14(), rand_q14(),
                      $urandom_range(63), $urandom_range(127));
  endfunction

  task automatic test_directed();
    send_word(make_point(FN_READ, 0, 0, 0, 0, 15, 37));
    send_word(make_point(FN_PLOT, 16384, 0, 16384, 0, 0, 0));
    send_word(make_point(FN_READ, 0, 0, 0, 0, 15, 66));
    send_word(make_point(FN_PLOT, 16384, 0, 16384, 0, 0, 0));
    send_word(make_point(FN_PLOT, -16384, 0, -16384, 0, 0, 0));
    send_word(make_point(FN_PLOT, 0, 16384, 0, 16384, 0, 0));
    send_word(make_point(FN_PLOT, 0, -16384, 0, -16384, 0, 0));
    send_word(make_point(FN_PLOT, 16384, 16384, 16384, 16384, 63, 127));
    send_word(make_point(FN_PLOT, -16384, -16384, -16384, -16384, 63, 127));
    send_word(make_point(FN_READ, -1, -1, -1, -1, 49, 74));
    send_word(make_point(FN_READ, 0, 0, 0, 0, 50, 0));
    send_word(make_point(FN_READ, 0, 0, 0, 0, 0, 75));
    send_word(make_point(FN_READ, 0, 0, 0, 0, 63, 127));
    send_word(make_point(FN_NOP, 16384, -16384, 16384, -16384, 63, 127));
    send_word(make_point(FN_CLEAR, 0, 0, 0, 0, 0, 0));
    send_word(make_point(FN_READ, 0, 0, 0, 0, 15, 66));
    // point behind the camera, then off screen, then a far point whose 1/z is tiny
    write_view(63, 63, 255, 1, 16384, 0, 16384, 0);
    send_word(make_point(FN_PLOT, 16384, 0, -16384, 0, 0, 0));
    send_word(make_point(FN_PLOT, 16384, 0, 16384, 0, 0, 0));
    write_view(0, 0, 1, 255, -16384, 16384, -16384, 16384);
    send_word(make_point(FN_PLOT, 16384, 0, 16384, 0, 0, 0));
    send_word(make_point(FN_PLOT, 16384, 0, 16384, 0, 0, 0));
    write_view(63, 63, 255, 255, -16384, -16384, 16384, -16384);
    send_word(make_point(FN_PLOT, 0, 16384, 16384, 0, 0, 0));
    send_word(make_point(FN_PLOT, 16384, 16384, 16384, 16384, 0, 0));
    drain();
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if (i % 90 == 89) random_view();
      send_word(random_point());
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    for (int i = 0; i < 24; i++) send_word(random_point());
    drain();
  endtask

  initial begin
    m_major = 20; m_minor = 8; m_cam = 15; m_obj = 35;
    m_cy = 16384; m_sy = 0; m_cp = 16384; m_sp = 0;
    wipe_frame();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    write_view(20, 8, 15, 35, 16384, 0, 16384, 0);
    test_random(450, 0, 0);
    test_random(450, 66, 0);
    test_random(450, 0, 66);
    test_random(450, 24, 24);
    test_backpressure();
    write_view(63, 63, 255, 255, -16384, 16384, 16384, -16384);
    test_random(30, 24, 24);
    $display("covered %0d plots (%0d stored), %0d reads, %0d clears, %0d no-ops",
             n_plot, n_hit, n_read, n_clear, n_nop);
    $display("across %0d register settings; %0d mismatches", n_views, errors);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== torus_point_zbuffer_plotter.f =====
src/tpz_pkg.sv
src/tpz_div.sv
src/tpz_ctrl.sv
src/tpz_dp.sv
src/torus_point_zbuffer_plotter.sv
tb/sv/torus_point_zbuffer_plotter_test.sv
